[design/clts_pkg.sv]
package clts_pkg;

    // Character buffer geometry
    localparam int BUFFER_DEPTH = 256;
    localparam int BUF_AW       = $clog2(BUFFER_DEPTH);
    localparam int BUF_CW       = $clog2(BUFFER_DEPTH + 1);

    // Input command codes
    localparam logic [1:0] CMD_TICK       = 2'd0;
    localparam logic [1:0] CMD_CHAR       = 2'd1;
    localparam logic [1:0] CMD_CLEAR_REQ  = 2'd2;
    localparam logic [1:0] CMD_CURSOR_REQ = 2'd3;

    // Done codes
    localparam logic [1:0] DONE_NONE   = 2'd0;
    localparam logic [1:0] DONE_STRING = 2'd1;
    localparam logic [1:0] DONE_CLEAR  = 2'd2;
    localparam logic [1:0] DONE_CURSOR = 2'd3;

    // Configuration register indexes
    localparam logic [2:0] CFG_STARTUP_TICKS = 3'd0;
    localparam logic [2:0] CFG_FONT          = 3'd1;
    localparam logic [2:0] CFG_TWO_LINES     = 3'd2;
    localparam logic [2:0] CFG_DISPLAY_ON    = 3'd3;
    localparam logic [2:0] CFG_CURSOR_ON     = 3'd4;
    localparam logic [2:0] CFG_BLINK_ON      = 3'd5;

    // LCD command bytes
    localparam logic [7:0] LCD_FUNC_SET_BASE = 8'h30;
    localparam logic [7:0] LCD_DISP_CTL_BASE = 8'h08;
    localparam logic [7:0] LCD_CLEAR         = 8'h01;

    localparam logic [7:0] STARTUP_TICKS_RST = 8'd20;

    typedef enum logic [2:0] {
        STEP_FUNC_SET = 3'b001,
        STEP_DISP_CTL = 3'b010,
        STEP_CLEAR    = 3'b100
    } init_step_t;

    typedef enum logic [3:0] {
        JOB_IDLE   = 4'b0001,
        JOB_WRITE  = 4'b0010,
        JOB_CLEAR  = 4'b0100,
        JOB_CURSOR = 4'b1000
    } job_t;

    typedef struct packed {
        logic [1:0] cmd;
        logic [7:0] char_value;
        logic       last_char;
        logic [7:0] row_base;
        logic [7:0] column_offset;
    } in_item_t;

    typedef struct packed {
        logic       accepted;
        logic       reg_select;
        logic       read_write;
        logic       enable_line;
        logic [7:0] data_bus;
        logic [1:0] done_code;
        logic       init_complete;
    } out_item_t;

    typedef struct packed {
        logic [7:0] startup_ticks;
        logic       font_bit;
        logic       two_lines_bit;
        logic       display_on_bit;
        logic       cursor_on_bit;
        logic       blink_on_bit;
    } cfg_t;

    typedef struct packed {
        logic              we;
        logic [BUF_AW-1:0] waddr;
        logic [7:0]        wdata;
        logic [BUF_AW-1:0] raddr;
    } mem_req_t;

endpackage

[design/clts_char_ram.sv]
module clts_char_ram
    import clts_pkg::*;
(
    input  logic       aclk,
    input  mem_req_t   req,
    output logic [7:0] rd_data
);

    logic [7:0] mem [BUFFER_DEPTH];
    logic [7:0] rd_data_reg;

    // Write port
    always_ff @(posedge aclk) begin
        if (req.we) begin
            mem[req.waddr] <= req.wdata;
        end
    end

    // Registered read, forward a same-cycle write to the same entry
    always_ff @(posedge aclk) begin
        if (req.we && (req.waddr == req.raddr)) begin
            rd_data_reg <= req.wdata;
        end else begin
            rd_data_reg <= mem[req.raddr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[design/clts_ctrl.sv]
module clts_ctrl
    import clts_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       accept,
    input  in_item_t   item,
    input  cfg_t       cfg,
    input  logic [7:0] rd_data,
    output mem_req_t   mem_req,
    output out_item_t  result
);

    logic              init_done_reg, init_done_next;
    logic [7:0]        startup_count_reg, startup_count_next;
    init_step_t        init_step_reg, init_step_next;
    job_t              active_job_reg, active_job_next;
    logic              loading_reg, loading_next;
    logic              enable_reg, enable_next;
    logic              rs_reg, rs_next;
    logic [7:0]        bus_reg, bus_next;
    logic [BUF_CW-1:0] char_total_reg, char_total_next;
    logic [BUF_CW-1:0] send_index_reg, send_index_next;
    logic [7:0]        cursor_reg, cursor_next;
    logic [BUF_CW-1:0] total_base;
    logic              accepted;
    logic [1:0]        done;

    // Next state for one accepted item
    always_comb begin
        init_done_next     = init_done_reg;
        startup_count_next = startup_count_reg;
        init_step_next     = init_step_reg;
        active_job_next    = active_job_reg;
        loading_next       = loading_reg;
        enable_next        = enable_reg;
        rs_next            = rs_reg;
        bus_next           = bus_reg;
        char_total_next    = char_total_reg;
        send_index_next    = send_index_reg;
        cursor_next        = cursor_reg;
        accepted           = 1'b0;
        done               = DONE_NONE;
        total_base         = loading_reg ? char_total_reg : '0;
        mem_req.we         = 1'b0;
        mem_req.waddr      = total_base[BUF_AW-1:0];
        mem_req.wdata      = item.char_value;

        if (accept) begin
            if (item.cmd == CMD_TICK) begin
                if (init_done_reg) begin
                    // Advance the running job
                    unique case (active_job_reg)
                        JOB_WRITE: begin
                            if (enable_reg) begin
                                enable_next = 1'b0;
                            end else if (send_index_reg >= char_total_reg) begin
                                active_job_next = JOB_IDLE;
                                send_index_next = '0;
                                char_total_next = '0;
                                done            = DONE_STRING;
                            end else begin
                                enable_next     = 1'b1;
                                rs_next         = 1'b1;
                                bus_next        = rd_data;
                                send_index_next = send_index_reg + 1'b1;
                            end
                        end
                        JOB_CLEAR, JOB_CURSOR: begin
                            if (enable_reg) begin
                                enable_next     = 1'b0;
                                active_job_next = JOB_IDLE;
                                done = (active_job_reg == JOB_CLEAR) ? DONE_CLEAR : DONE_CURSOR;
                            end else begin
                                enable_next = 1'b1;
                                rs_next     = 1'b0;
                                bus_next = (active_job_reg == JOB_CLEAR) ? LCD_CLEAR : cursor_reg;
                            end
                        end
                        default: begin
                        end
                    endcase
                end else if (startup_count_reg < cfg.startup_ticks) begin
                    startup_count_next = startup_count_reg + 8'd1;
                end else if (enable_reg) begin
                    // Drop the strobe and move to the next init command
                    enable_next = 1'b0;
                    unique case (init_step_reg)
                        STEP_FUNC_SET: init_step_next = STEP_DISP_CTL;
                        STEP_DISP_CTL: init_step_next = STEP_CLEAR;
                        default:       init_done_next = 1'b1;
                    endcase
                end else begin
                    // Raise the strobe with the current init command
                    enable_next = 1'b1;
                    rs_next     = 1'b0;
                    unique case (init_step_reg)
                        STEP_FUNC_SET: bus_next = LCD_FUNC_SET_BASE |
                            {4'b0000, cfg.two_lines_bit, cfg.font_bit, 2'b00};
                        STEP_DISP_CTL: bus_next = LCD_DISP_CTL_BASE |
                            {5'b00000, cfg.display_on_bit, cfg.cursor_on_bit,
                             cfg.blink_on_bit};
                        default:       bus_next = LCD_CLEAR;
                    endcase
                end
            end else if (active_job_reg != JOB_IDLE) begin
                accepted = 1'b0;
            end else if (item.cmd == CMD_CHAR) begin
                // Append the character, drop it once the buffer is full
                accepted     = 1'b1;
                loading_next = 1'b1;
                if (total_base < BUF_CW'(BUFFER_DEPTH)) begin
                    mem_req.we      = 1'b1;
                    char_total_next = total_base + 1'b1;
                end else begin
                    char_total_next = total_base;
                end
                if (item.last_char) begin
                    loading_next    = 1'b0;
                    send_index_next = '0;
                    active_job_next = JOB_WRITE;
                end
            end else if (loading_reg) begin
                accepted = 1'b0;
            end else if (item.cmd == CMD_CLEAR_REQ) begin
                accepted        = 1'b1;
                active_job_next = JOB_CLEAR;
            end else begin
                accepted        = 1'b1;
                cursor_next     = item.row_base + item.column_offset;
                active_job_next = JOB_CURSOR;
            end
        end

        // Prefetch the character that the next strobe will send
        mem_req.raddr = send_index_next[BUF_AW-1:0];
    end

    // Result from the updated line levels
    always_comb begin
        result.accepted      = accepted;
        result.reg_select    = rs_next;
        result.read_write    = 1'b0;
        result.enable_line   = enable_next;
        result.data_bus      = bus_next;
        result.done_code     = done;
        result.init_complete = init_done_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            init_done_reg     <= 1'b0;
            startup_count_reg <= '0;
            init_step_reg     <= STEP_FUNC_SET;
            active_job_reg    <= JOB_IDLE;
            loading_reg       <= 1'b0;
            enable_reg        <= 1'b0;
            rs_reg            <= 1'b0;
            bus_reg           <= '0;
            char_total_reg    <= '0;
            send_index_reg    <= '0;
            cursor_reg        <= '0;
        end else begin
            init_done_reg     <= init_done_next;
            startup_count_reg <= startup_count_next;
            init_step_reg     <= init_step_next;
            active_job_reg    <= active_job_next;
            loading_reg       <= loading_next;
            enable_reg        <= enable_next;
            rs_reg            <= rs_next;
            bus_reg           <= bus_next;
            char_total_reg    <= char_total_next;
            send_index_reg    <= send_index_next;
            cursor_reg        <= cursor_next;
        end
    end

`ifndef SYNTH
    a_send_within_total: assert property (@(posedge aclk) disable iff (!aresetn)
        send_index_reg <= char_total_reg)
        else $error("send index ran past the stored character count");

    a_loading_only_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        loading_reg |-> (active_job_reg == JOB_IDLE))
        else $error("string loading while a job is pending");

    a_request_keeps_lines: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && (item.cmd != CMD_TICK)) |=> ($stable(enable_reg) && $stable(bus_reg)))
        else $error("request item changed the bus lines");

    a_init_done_sticks: assert property (@(posedge aclk) disable iff (!aresetn)
        init_done_reg |=> init_done_reg)
        else $error("init complete dropped");
`endif

endmodule

[design/char_lcd_tick_sequencer_unit.sv]
// Channel  | Handshake                | Payload
// s_       | s_valid / s_ready        | s_item   (in_item_t: one tick or request)
// m_       | m_valid / m_ready        | m_item   (out_item_t: one result per item)
// cfg_     | cfg_valid / cfg_ready    | cfg_index, cfg_data (register write)
//
// One item a cycle while s_ready is high: each item is a single read-modify-write
// of the sequencer state; the character buffer read at the send index is prefetched.
// Results wait in one output register; s_ready is high while it is empty or drained.
// Reset is synchronous, active low; the character buffer needs no clearing pass.
// Configuration writes are always ready and take effect at the next item.
module char_lcd_tick_sequencer_unit
    import clts_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  in_item_t   s_item,
    output logic       m_valid,
    input  logic       m_ready,
    output out_item_t  m_item,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [2:0] cfg_index,
    input  logic [7:0] cfg_data
);

    cfg_t      cfg_reg;
    logic      m_valid_reg;
    out_item_t m_item_reg;
    logic      accept;
    mem_req_t  mem_req;
    logic [7:0] rd_data;
    out_item_t result;

    assign cfg_ready = 1'b1;
    assign s_ready   = !m_valid_reg || m_ready;
    assign accept    = s_valid && s_ready;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.startup_ticks  <= STARTUP_TICKS_RST;
            cfg_reg.font_bit       <= 1'b0;
            cfg_reg.two_lines_bit  <= 1'b1;
            cfg_reg.display_on_bit <= 1'b1;
            cfg_reg.cursor_on_bit  <= 1'b0;
            cfg_reg.blink_on_bit   <= 1'b0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_STARTUP_TICKS: cfg_reg.startup_ticks  <= cfg_data;
                CFG_FONT:          cfg_reg.font_bit       <= cfg_data[0];
                CFG_TWO_LINES:     cfg_reg.two_lines_bit  <= cfg_data[0];
                CFG_DISPLAY_ON:    cfg_reg.display_on_bit <= cfg_data[0];
                CFG_CURSOR_ON:     cfg_reg.cursor_on_bit  <= cfg_data[0];
                CFG_BLINK_ON:      cfg_reg.blink_on_bit   <= cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    clts_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .accept  (accept),
        .item    (s_item),
        .cfg     (cfg_reg),
        .rd_data (rd_data),
        .mem_req (mem_req),
        .result  (result)
    );

    clts_char_ram u_ram (
        .aclk    (aclk),
        .req     (mem_req),
        .rd_data (rd_data)
    );

    // Output register: hold the item until taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (accept) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            m_item_reg <= result;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

endmodule

[tb/tb_top.sv]
`default_nettype none

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import clts_pkg::*;

    logic       aclk = 1'b0;
    logic       aresetn;
    logic       s_valid;
    logic       s_ready;
    in_item_t   s_item;
    logic       m_valid;
    logic       m_ready;
    out_item_t  m_item;
    logic       cfg_valid;
    logic       cfg_ready;
    logic [2:0] cfg_index;
    logic [7:0] cfg_data;

    char_lcd_tick_sequencer_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_item    (s_item),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_item    (m_item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // 12 ns clock
    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // Shadow copy of the sequencer: registers and bus state
    cfg_t        lcd_cfg;
    logic        lcd_init_done;
    logic [7:0]  lcd_startup_count;
    init_step_t  lcd_step;
    job_t        lcd_job;
    logic        lcd_loading;
    logic        lcd_en;
    logic        lcd_rs;
    logic [7:0]  lcd_bus;
    logic [7:0]  lcd_chars [BUFFER_DEPTH];
    logic [8:0]  lcd_char_total;
    logic [8:0]  lcd_send_idx;
    logic [7:0]  lcd_cursor;

    out_item_t   pending_results [$];
    int unsigned mismatch_count = 0;
    int unsigned items_sent = 0;
    bit          no_gaps = 1'b0;
    bit          hold_req = 1'b0;

    task automatic lcd_reset;
        lcd_cfg.startup_ticks  = STARTUP_TICKS_RST;
        lcd_cfg.font_bit       = 1'b0;
        lcd_cfg.two_lines_bit  = 1'b1;
        lcd_cfg.display_on_bit = 1'b1;
        lcd_cfg.cursor_on_bit  = 1'b0;
        lcd_cfg.blink_on_bit   = 1'b0;
        lcd_init_done     = 1'b0;
        lcd_startup_count = '0;
        lcd_step          = STEP_FUNC_SET;
        lcd_job           = JOB_IDLE;
        lcd_loading       = 1'b0;
        lcd_en            = 1'b0;
        lcd_rs            = 1'b0;
        lcd_bus           = '0;
        lcd_char_total    = '0;
        lcd_send_idx      = '0;
        lcd_cursor        = '0;
    endtask

    // Advance the power-up sequence by one tick
    task automatic lcd_init_tick;
        if (lcd_startup_count < lcd_cfg.startup_ticks) begin
            lcd_startup_count = lcd_startup_count + 8'd1;
        end else if (lcd_en) begin
            lcd_en = 1'b0;
            case (lcd_step)
                STEP_FUNC_SET: lcd_step = STEP_DISP_CTL;
                STEP_DISP_CTL: lcd_step = STEP_CLEAR;
                default: lcd_init_done = 1'b1;
            endcase
        end else begin
            lcd_rs = 1'b0;
            lcd_en = 1'b1;
            case (lcd_step)
                STEP_FUNC_SET: lcd_bus = LCD_FUNC_SET_BASE |
                    {4'b0, lcd_cfg.two_lines_bit, lcd_cfg.font_bit, 2'b0};
                STEP_DISP_CTL: lcd_bus = LCD_DISP_CTL_BASE |
                    {5'b0, lcd_cfg.display_on_bit, lcd_cfg.cursor_on_bit,
                     lcd_cfg.blink_on_bit};
                default: lcd_bus = LCD_CLEAR;
            endcase
        end
    endtask

    // Advance the running job by one tick and give its done code
    task automatic lcd_job_tick(output logic [1:0] done);
        done = DONE_NONE;
        case (lcd_job)
            JOB_WRITE: begin
                if (lcd_en) begin
                    lcd_en = 1'b0;
                end else if (lcd_send_idx >= lcd_char_total) begin
                    lcd_job        = JOB_IDLE;
                    lcd_send_idx   = '0;
                    lcd_char_total = '0;
                    done           = DONE_STRING;
                end else begin
                    lcd_rs       = 1'b1;
                    lcd_bus      = lcd_chars[lcd_send_idx[BUF_AW-1:0]];
                    lcd_en       = 1'b1;
                    lcd_send_idx = lcd_send_idx + 9'd1;
                end
            end
            JOB_CLEAR, JOB_CURSOR: begin
                if (lcd_en) begin
                    lcd_en  = 1'b0;
                    done    = (lcd_job == JOB_CLEAR) ? DONE_CLEAR : DONE_CURSOR;
                    lcd_job = JOB_IDLE;
                end else begin
                    lcd_rs  = 1'b0;
                    lcd_bus = (lcd_job == JOB_CLEAR) ? LCD_CLEAR : lcd_cursor;
                    lcd_en  = 1'b1;
                end
            end
            default: ;
        endcase
    endtask

    // Work out the bus levels and codes that one item leaves behind
    task automatic lcd_predict(input in_item_t it, output out_item_t res);
        logic [1:0] done;
        logic       taken;
        done  = DONE_NONE;
        taken = 1'b0;
        if (it.cmd == CMD_TICK) begin
            if (lcd_init_done) lcd_job_tick(done);
            else lcd_init_tick();
        end else if (lcd_job != JOB_IDLE) begin
            taken = 1'b0;
        end else if (it.cmd == CMD_CHAR) begin
            taken = 1'b1;
            if (!lcd_loading) begin
                lcd_loading    = 1'b1;
                lcd_char_total = '0;
            end
            // drop characters once the buffer is full
            if (lcd_char_total < BUFFER_DEPTH) begin
                lcd_chars[lcd_char_total[BUF_AW-1:0]] = it.char_value;
                lcd_char_total = lcd_char_total + 9'd1;
            end
            if (it.last_char) begin
                lcd_loading  = 1'b0;
                lcd_send_idx = '0;
                lcd_job      = JOB_WRITE;
            end
        end else if (lcd_loading) begin
            taken = 1'b0;
        end else if (it.cmd == CMD_CLEAR_REQ) begin
            taken   = 1'b1;
            lcd_job = JOB_CLEAR;
        end else begin
            taken      = 1'b1;
            lcd_cursor = it.row_base + it.column_offset;
            lcd_job    = JOB_CURSOR;
        end
        res.accepted      = taken;
        res.reg_select    = lcd_rs;
        res.read_write    = 1'b0;
        res.enable_line   = lcd_en;
        res.data_bus      = lcd_bus;
        res.done_code     = done;
        res.init_complete = lcd_init_done;
    endtask

    task automatic report_mismatch(string what, logic [7:0] got, logic [7:0] want);
        $display("[%0t] mismatch on %s: got %0h, want %0h", $realtime, what, got, want);
        mismatch_count++;
    endtask

    task automatic check_field(string field, logic [7:0] got, logic [7:0] want);
        if (got !== want) report_mismatch(field, got, want);
    endtask

    // Compare each result taken from the block with the oldest prediction
    always @(posedge aclk) begin : check_result
        out_item_t want;
        if (aresetn === 1'b1 && m_valid === 1'b1 && m_ready === 1'b1) begin
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected result", m_item.data_bus, 8'h00);
            end else begin
                want = pending_results.pop_front();
                check_field("accepted", 8'(m_item.accepted), 8'(want.accepted));
                check_field("reg_select", 8'(m_item.reg_select), 8'(want.reg_select));
                check_field("read_write", 8'(m_item.read_write), 8'(want.read_write));
                check_field("enable_line", 8'(m_item.enable_line), 8'(want.enable_line));
                check_field("data_bus", m_item.data_bus, want.data_bus);
                check_field("done_code", 8'(m_item.done_code), 8'(want.done_code));
                check_field("init_complete", 8'(m_item.init_complete),
                            8'(want.init_complete));
            end
        end
    end

    // Mostly no gap, sometimes a short one, rarely a long one
    function automatic int unsigned random_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 50);
    endfunction

    // Receiver: random stalls, plus a long hold-off on request
    initial begin : result_receiver
        int unsigned stall_left;
        int unsigned hold_left;
        stall_left = 0;
        hold_left  = 0;
        m_ready    = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                hold_left = 80;
                hold_req  = 1'b0;
            end
            if (hold_left != 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else if (no_gaps) begin
                m_ready <= 1'b1;
            end else begin
                if (stall_left == 0) stall_left = random_gap();
                if (stall_left != 0) begin
                    stall_left--;
                    m_ready <= 1'b0;
                end else begin
                    m_ready <= 1'b1;
                end
            end
        end
    end

    function automatic in_item_t make_item(logic [1:0] cmd);
        in_item_t it;
        it.cmd           = cmd;
        it.char_value    = 8'($urandom_range(0, 255));
        it.last_char     = 1'($urandom_range(0, 1));
        it.row_base      = 8'($urandom_range(0, 255));
        it.column_offset = 8'($urandom_range(0, 255));
        return it;
    endfunction

    // Offer one item, predict it on acceptance, then idle at random
    task automatic send_item(input in_item_t it);
        out_item_t res;
        int unsigned gap;
        s_valid <= 1'b1;
        s_item  <= it;
        do @(posedge aclk); while (s_ready !== 1'b1);
        lcd_predict(it, res);
        pending_results.push_back(res);
        items_sent++;
        @(negedge aclk);
        gap = no_gaps ? 0 : random_gap();
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
    endtask

    task automatic send_request(logic [1:0] cmd, logic [7:0] row, logic [7:0] col);
        in_item_t it;
        it               = make_item(cmd);
        it.row_base      = row;
        it.column_offset = col;
        send_item(it);
    endtask

    task automatic send_char(logic [7:0] value, logic is_last);
        in_item_t it;
        it            = make_item(CMD_CHAR);
        it.char_value = value;
        it.last_char  = is_last;
        send_item(it);
    endtask

    task automatic send_string(int unsigned len, bit with_last);
        for (int unsigned i = 0; i < len; i++)
            send_char(8'($urandom_range(0, 255)), with_last && (i == len - 1));
    endtask

    // Tick until init is over and no job is pending; slip in refused requests
    task automatic tick_until_idle(int unsigned noise_odds);
        while (!lcd_init_done || lcd_job != JOB_IDLE) begin
            if (noise_odds != 0 && $urandom_range(1, noise_odds) == 1)
                send_item(make_item(2'($urandom_range(1, 3))));
            else
                send_item(make_item(CMD_TICK));
        end
    endtask

    // Hold the input low until every prediction has been matched
    task automatic drain_results;
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (3) @(negedge aclk);
    endtask

    task automatic write_register(logic [2:0] idx, logic [7:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge aclk); while (cfg_ready !== 1'b1);
        case (idx)
            CFG_STARTUP_TICKS: lcd_cfg.startup_ticks  = value;
            CFG_FONT:          lcd_cfg.font_bit       = value[0];
            CFG_TWO_LINES:     lcd_cfg.two_lines_bit  = value[0];
            CFG_DISPLAY_ON:    lcd_cfg.display_on_bit = value[0];
            CFG_CURSOR_ON:     lcd_cfg.cursor_on_bit  = value[0];
            CFG_BLINK_ON:      lcd_cfg.blink_on_bit   = value[0];
            default: ;
        endcase
        @(negedge aclk);
        cfg_valid <= 1'b0;
        @(negedge aclk);
    endtask

    // Power-up: requests before init, startup count moved up then below the count,
    // and every flag flipped from its reset value in time for its command
    task automatic test_power_up;
        send_request(CMD_CLEAR_REQ, 8'h00, 8'h00);
        send_request(CMD_CURSOR_REQ, 8'hFF, 8'h01);
        send_char(8'h41, 1'b1);
        repeat (5) send_item(make_item(CMD_TICK));
        drain_results();
        write_register(CFG_STARTUP_TICKS, 8'd255);
        repeat (3) send_item(make_item(CMD_TICK));
        drain_results();
        write_register(CFG_FONT, 8'd1);
        write_register(CFG_TWO_LINES, 8'd0);
        write_register(CFG_STARTUP_TICKS, 8'd0);
        repeat (2) send_item(make_item(CMD_TICK));
        drain_results();
        write_register(CFG_DISPLAY_ON, 8'd0);
        write_register(CFG_CURSOR_ON, 8'd1);
        write_register(CFG_BLINK_ON, 8'd1);
        tick_until_idle(0);
    endtask

    // Jobs after init: cursor wrap, busy and loading refusals, edge characters
    task automatic test_job_cases;
        send_request(CMD_CURSOR_REQ, 8'hFF, 8'hFF);
        send_request(CMD_CLEAR_REQ, 8'h00, 8'h00);
        tick_until_idle(0);
        send_request(CMD_CURSOR_REQ, 8'h00, 8'h00);
        tick_until_idle(0);
        send_char(8'h00, 1'b0);
        send_request(CMD_CLEAR_REQ, 8'h00, 8'h00);
        send_request(CMD_CURSOR_REQ, 8'h40, 8'h05);
        send_char(8'hFF, 1'b1);
        send_char(8'h55, 1'b1);
        tick_until_idle(0);
        send_char(8'h80, 1'b1);
        tick_until_idle(0);
    endtask

    // Stall the result side for a long stretch while items keep coming
    task automatic test_back_pressure;
        no_gaps  = 1'b1;
        hold_req = 1'b1;
        send_request(CMD_CURSOR_REQ, 8'h40, 8'h0A);
        send_string(6, 1'b0);
        repeat (30) send_item(make_item(CMD_TICK));
        send_char(8'h7E, 1'b1);
        tick_until_idle(0);
        no_gaps = 1'b0;
        drain_results();
    endtask

    // Fill the buffer past its depth; the overflow is dropped but still accepted
    task automatic test_buffer_overflow;
        send_string(BUFFER_DEPTH + 3, 1'b1);
        tick_until_idle(16);
        drain_results();
    endtask

    function automatic logic [7:0] pick_byte();
        case ($urandom_range(0, 3))
            0: return 8'h00;
            1: return 8'hFF;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // Random jobs with random content, mixed with noise and broken strings
    task automatic test_random_traffic(int unsigned item_budget);
        int unsigned stop_at;
        int unsigned pick;
        stop_at = items_sent + item_budget;
        while (items_sent < stop_at) begin
            if ($urandom_range(0, 9) == 0) no_gaps = ~no_gaps;
            pick = $urandom_range(0, 19);
            if (pick < 8) begin
                send_string($urandom_range(1, (pick == 0) ? 40 : 8), 1'b1);
            end else if (pick < 11) begin
                send_item(make_item(CMD_CLEAR_REQ));
            end else if (pick < 15) begin
                send_item(make_item(CMD_CURSOR_REQ));
            end else if (pick < 17) begin
                repeat ($urandom_range(1, 5)) send_item(make_item(2'($urandom_range(0, 3))));
            end else if (pick < 19) begin
                // string left open, then a request that it must refuse
                send_string($urandom_range(1, 4), 1'b0);
                send_item(make_item(2'($urandom_range(2, 3))));
            end else begin
                drain_results();
                write_register(CFG_STARTUP_TICKS, pick_byte());
                write_register(CFG_FONT, 8'($urandom_range(0, 1)));
                write_register(CFG_TWO_LINES, 8'($urandom_range(0, 1)));
                write_register(CFG_DISPLAY_ON, 8'($urandom_range(0, 1)));
                write_register(CFG_CURSOR_ON, 8'($urandom_range(0, 1)));
                write_register(CFG_BLINK_ON, 8'($urandom_range(0, 1)));
            end
            tick_until_idle(6);
            repeat ($urandom_range(0, 2)) send_item(make_item(CMD_TICK));
        end
        no_gaps = 1'b0;
    endtask

    initial begin
        aresetn   = 1'b0;
        s_valid   = 1'b0;
        s_item    = '0;
        cfg_valid = 1'b0;
        cfg_index = CFG_STARTUP_TICKS;
        cfg_data  = '0;
        lcd_reset();
        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        test_power_up();
        test_job_cases();
        test_back_pressure();
        test_buffer_overflow();
        test_random_traffic(700);

        drain_results();
        repeat (20) @(posedge aclk);
        if (mismatch_count == 0 && pending_results.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #(10_000_000);
        $display("== FAIL ==");
        $finish;
    end

endmodule

`default_nettype wire

[sim.f]
design/clts_pkg.sv
design/clts_char_ram.sv
design/clts_ctrl.sv
design/char_lcd_tick_sequencer_unit.sv
tb/tb_top.sv
